FILE: sv/mcnvr_pkg.sv
// Package with the shared widths, command codes and register indexes of the MIDI router.
package mcnvr_pkg;

   // Field widths of the message beat, the result beat and the configuration port, and the notes per channel.
   localparam int CMD_W   = 3;
   localparam int CHAN_W  = 4;
   localparam int NOTE_W  = 7;
   localparam int VEL_W   = 7;
   localparam int CBND_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int NOTES_PER_CHAN = 128;

   // Decoded message kinds; anything above a program change is not channel voice.
   localparam logic [CMD_W-1:0] CMD_OTHER_VOICE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_NOTE_ON     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_NOTE_OFF    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PROG_CHANGE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NOT_VOICE   = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_LOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_HIGH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PROG_PASS  = 3'd6;

endpackage

FILE: sv/mcnvr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mcnvr_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of an address written in the same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/midi_channel_note_velocity_router_top.sv
// Top level of the MIDI channel, note and velocity router.
// Pipeline: an accepted beat goes to the compute stage, then to the output register.
// Throughput: one message per cycle while req_stall is low; the velocity table is read
// at acceptance and written back when the compute stage advances, with the last write
// forwarded to the following message. Reset: configuration returns to its defaults,
// then a clearing pass zeroes the velocity table while req_stall is held high.
module midi_channel_note_velocity_router_top #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mcnvr_pkg::CMD_W-1:0]         req_command,
   input  logic [mcnvr_pkg::CHAN_W-1:0]        req_chan,
   input  logic [mcnvr_pkg::NOTE_W-1:0]        req_note_num,
   input  logic [mcnvr_pkg::VEL_W-1:0]         req_velocity_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_excluded,
   output logic [mcnvr_pkg::VEL_W-1:0]         rsp_vel_used,
   input  logic                                csr_write,
   input  logic [mcnvr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mcnvr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import mcnvr_pkg::*;

   localparam int DEPTH = NUM_CHANNELS * NOTES_PER_CHAN;
   localparam int AW    = $clog2(DEPTH);

   // Configuration registers.
   logic [CBND_W-1:0] chan_low_ff, chan_high_ff;
   logic [NOTE_W-1:0] note_low_ff, note_high_ff;
   logic [VEL_W-1:0]  vel_low_ff, vel_high_ff;
   logic              prog_pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_low_ff  <= CBND_W'(1);
         chan_high_ff <= CBND_W'(16);
         note_low_ff  <= '0;
         note_high_ff <= '1;
         vel_low_ff   <= '0;
         vel_high_ff  <= '1;
         prog_pass_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CHAN_LOW:  chan_low_ff  <= csr_wdata[CBND_W-1:0];
            CSR_CHAN_HIGH: chan_high_ff <= csr_wdata[CBND_W-1:0];
            CSR_NOTE_LOW:  note_low_ff  <= csr_wdata[NOTE_W-1:0];
            CSR_NOTE_HIGH: note_high_ff <= csr_wdata[NOTE_W-1:0];
            CSR_VEL_LOW:   vel_low_ff   <= csr_wdata[VEL_W-1:0];
            CSR_VEL_HIGH:  vel_high_ff  <= csr_wdata[VEL_W-1:0];
            CSR_PROG_PASS: prog_pass_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Clearing pass over the velocity table after reset.
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Pipeline handshake: the compute stage moves on when the output register is free.
   logic s1_valid_ff, out_valid_ff;
   logic s1_advance, req_accept;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = clr_busy_ff || (s1_valid_ff && !s1_advance);

   // Compute stage registers, loaded with each accepted message beat.
   logic [CMD_W-1:0]  s1_command_ff;
   logic [CHAN_W-1:0] s1_chan_ff;
   logic [NOTE_W-1:0] s1_note_ff;
   logic [VEL_W-1:0]  s1_vel_in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_command_ff <= req_command;
         s1_chan_ff    <= req_chan;
         s1_note_ff    <= req_note_num;
         s1_vel_in_ff  <= req_velocity_in;
      end
   end

   // Velocity table and its write port.
   // The entry is chan*128 + note, cut down to the address width of the table.
   logic [AW-1:0]    rd_addr, s1_addr, wr_addr;
   logic [VEL_W-1:0] rd_data, wr_data;
   logic             wr_en, s1_write;
   logic [VEL_W-1:0] vel_on;

   assign rd_addr = AW'({req_chan, req_note_num});
   assign s1_addr = AW'({s1_chan_ff, s1_note_ff});
   assign vel_on  = (s1_vel_in_ff == '0) ? VEL_W'(1) : s1_vel_in_ff;

   assign wr_en   = clr_busy_ff || s1_write;
   assign wr_addr = clr_busy_ff ? clr_addr_ff : s1_addr;
   assign wr_data = clr_busy_ff ? '0 : vel_on;

   mcnvr_ram #(
      .WIDTH (VEL_W),
      .DEPTH (DEPTH)
   ) u_vel_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Forwarding of the most recent note-on write, which the RAM read may have missed.
   logic             fwd_valid_ff;
   logic [AW-1:0]    fwd_addr_ff;
   logic [VEL_W-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_write) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_write) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= vel_on;
      end
   end

   // Routing decision for the message in the compute stage.
   logic              cmd_voice, chan_ok, route_ok, note_bad;
   logic [CBND_W-1:0] chan_ext, chan_plus;
   logic [VEL_W-1:0]  stored_vel, s1_vel;
   logic              s1_excluded;

   always_comb begin
      stored_vel = (fwd_valid_ff && fwd_addr_ff == s1_addr) ? fwd_data_ff : rd_data;
      cmd_voice  = s1_command_ff < CMD_NOT_VOICE;
      chan_ext   = {1'b0, s1_chan_ff};
      chan_plus  = chan_ext + CBND_W'(1);
      chan_ok    = !(chan_plus < chan_low_ff) && !(chan_plus > chan_high_ff)
                   && (chan_ext < CBND_W'(NUM_CHANNELS));
      route_ok   = cmd_voice && chan_ok;

      case (s1_command_ff)
         CMD_NOTE_ON:  s1_vel = vel_on;
         CMD_NOTE_OFF: s1_vel = stored_vel;
         default:      s1_vel = '0;
      endcase
      if (!route_ok) begin
         s1_vel = '0;
      end

      note_bad = (s1_note_ff < note_low_ff) || (s1_note_ff > note_high_ff)
                 || (s1_vel < vel_low_ff) || (s1_vel > vel_high_ff);

      case (s1_command_ff)
         CMD_NOTE_ON:     s1_excluded = note_bad;
         CMD_NOTE_OFF:    s1_excluded = note_bad;
         CMD_PROG_CHANGE: s1_excluded = !prog_pass_ff;
         default:         s1_excluded = 1'b0;
      endcase
      if (!route_ok) begin
         s1_excluded = 1'b1;
      end

      s1_write = s1_advance && route_ok && (s1_command_ff == CMD_NOTE_ON);
   end

   // Output register holding the result beat until it is taken.
   logic             out_excluded_ff;
   logic [VEL_W-1:0] out_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_excluded_ff <= s1_excluded;
         out_vel_ff      <= s1_vel;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_excluded = out_excluded_ff;
   assign rsp_vel_used = out_vel_ff;

endmodule

FILE: dv/midi_channel_note_velocity_router_top_tb.sv
// Self-checking testbench for the MIDI channel, note and velocity router, driven beat by beat.
`timescale 1ns / 100ps

module midi_channel_note_velocity_router_top_tb;
   import mcnvr_pkg::*;

   localparam int NUM_CH      = 16;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BEATS = 90;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CHAN_W-1:0] chan;
      logic [NOTE_W-1:0] note_num;
      logic [VEL_W-1:0]  velocity_in;
   } midi_msg_type;

   typedef struct packed {
      logic             excluded;
      logic [VEL_W-1:0] vel_used;
   } route_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command = '0;
   logic [CHAN_W-1:0]     req_chan = '0;
   logic [NOTE_W-1:0]     req_note_num = '0;
   logic [VEL_W-1:0]      req_velocity_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_excluded;
   logic [VEL_W-1:0]      rsp_vel_used;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   midi_channel_note_velocity_router_top #(
      .NUM_CHANNELS(NUM_CH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_chan(req_chan),
      .req_note_num(req_note_num),
      .req_velocity_in(req_velocity_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_excluded(rsp_excluded),
      .rsp_vel_used(rsp_vel_used),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Local copy of the router's registers and of its velocity table.
   logic [CBND_W-1:0] cfg_chan_low  = 5'd1;
   logic [CBND_W-1:0] cfg_chan_high = 5'd16;
   logic [NOTE_W-1:0] cfg_note_low  = 7'd0;
   logic [NOTE_W-1:0] cfg_note_high = 7'd127;
   logic [VEL_W-1:0]  cfg_vel_low   = 7'd0;
   logic [VEL_W-1:0]  cfg_vel_high  = 7'd127;
   logic              cfg_prog_pass = 1'b1;
   logic [VEL_W-1:0]  vel_table [NUM_CH*NOTES_PER_CHAN];

   midi_msg_type pending_msgs[$];
   route_type    route_expect[$];
   int           live_slots[$];

   int send_gap = 0;
   int recv_gap = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int msgs_queued = 0;
   int settings_used = 0;
   int results_checked = 0;
   int excluded_seen = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int hold_count = 0;
   logic hold_armed = 1'b0;
   wire  long_hold_active = hold_armed && (hold_count < LONG_HOLD);

   always #5 clock = ~clock;

   // A note message is rejected when its note or its velocity lies outside the window.
   function automatic logic outside_window(logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
      return note < cfg_note_low || note > cfg_note_high ||
             vel < cfg_vel_low || vel > cfg_vel_high;
   endfunction

   // Work out the routing of one accepted message and queue it as expected.
   function automatic void predict_route(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                                         logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vin);
      route_type r;
      int        slot;
      r.excluded = 1'b0;
      r.vel_used = '0;
      if (cmd > CMD_PROG_CHANGE) begin
         r.excluded = 1'b1;
      end else if (int'(ch) < int'(cfg_chan_low) - 1 || int'(ch) > int'(cfg_chan_high) - 1 ||
                   int'(ch) >= NUM_CH) begin
         r.excluded = 1'b1;
      end else begin
         slot = int'(ch) * NOTES_PER_CHAN + int'(note);
         case (cmd)
            CMD_NOTE_ON: begin
               r.vel_used = (vin == '0) ? 7'd1 : vin;
               vel_table[slot] = r.vel_used;
               r.excluded = outside_window(note, r.vel_used);
            end
            CMD_NOTE_OFF: begin
               r.vel_used = vel_table[slot];
               r.excluded = outside_window(note, r.vel_used);
            end
            CMD_PROG_CHANGE: r.excluded = !cfg_prog_pass;
            default: ;
         endcase
      end
      route_expect.push_back(r);
   endfunction

   // Values clustered around the edges of a window, with plain random ones mixed in.
   function automatic logic [6:0] near_bound(logic [6:0] lo, logic [6:0] hi);
      logic [6:0] v;
      case ($urandom_range(3, 0))
         0: v = lo - 7'd1 + 7'($urandom_range(2, 0));
         1: v = hi - 7'd1 + 7'($urandom_range(2, 0));
         default: v = 7'($urandom_range(127, 0));
      endcase
      return v;
   endfunction

   function automatic void queue_msg(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                                     logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vin);
      midi_msg_type m;
      m.command     = cmd;
      m.chan        = ch;
      m.note_num    = note;
      m.velocity_in = vin;
      pending_msgs.push_back(m);
      msgs_queued++;
   endfunction

   // Mostly note traffic, with note-offs often aimed at notes that were switched on.
   function automatic void queue_random_msgs(int count);
      logic [CMD_W-1:0]  cmd;
      logic [CHAN_W-1:0] ch;
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  vin;
      int                pick;
      int                slot;
      repeat (count) begin
         pick = $urandom_range(99, 0);
         ch   = 4'(near_bound(7'(cfg_chan_low) - 7'd1, 7'(cfg_chan_high) - 7'd1));
         note = near_bound(cfg_note_low, cfg_note_high);
         vin  = ($urandom_range(9, 0) == 0) ? '0 : near_bound(cfg_vel_low, cfg_vel_high);
         if (pick < 35) begin
            cmd = CMD_NOTE_ON;
            live_slots.push_back({ch, note});
            if (live_slots.size() > 32) void'(live_slots.pop_front());
         end else if (pick < 65) begin
            cmd = CMD_NOTE_OFF;
            if (live_slots.size() != 0 && $urandom_range(9, 0) < 6) begin
               slot = live_slots[$urandom_range(live_slots.size() - 1, 0)];
               ch   = slot[10:7];
               note = slot[6:0];
            end
         end else if (pick < 75) begin
            cmd = CMD_PROG_CHANGE;
         end else if (pick < 87) begin
            cmd = CMD_OTHER_VOICE;
         end else begin
            cmd = CMD_NOT_VOICE + 3'($urandom_range(3, 0));
         end
         queue_msg(cmd, ch, note, vin);
      end
   endfunction

   // One register write, mirrored into the local copy with the register's own width.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CHAN_LOW:  cfg_chan_low  = data[CBND_W-1:0];
         CSR_CHAN_HIGH: cfg_chan_high = data[CBND_W-1:0];
         CSR_NOTE_LOW:  cfg_note_low  = data[NOTE_W-1:0];
         CSR_NOTE_HIGH: cfg_note_high = data[NOTE_W-1:0];
         CSR_VEL_LOW:   cfg_vel_low   = data[VEL_W-1:0];
         CSR_VEL_HIGH:  cfg_vel_high  = data[VEL_W-1:0];
         CSR_PROG_PASS: cfg_prog_pass = data[0];
         default: ;
      endcase
   endtask

   // Wait at falling edges until every queued beat has been sent and answered.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_msgs.size() != 0 || req_valid || route_expect.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write every register while idle, then send a batch of random beats.
   task automatic run_phase(input logic [6:0] cl, input logic [6:0] chh,
                            input logic [6:0] nl, input logic [6:0] nh,
                            input logic [6:0] vl, input logic [6:0] vh,
                            input logic [6:0] pp, input int count);
      write_reg(CSR_CHAN_LOW, cl);
      write_reg(CSR_CHAN_HIGH, chh);
      write_reg(CSR_NOTE_LOW, nl);
      write_reg(CSR_NOTE_HIGH, nh);
      write_reg(CSR_VEL_LOW, vl);
      write_reg(CSR_VEL_HIGH, vh);
      write_reg(CSR_PROG_PASS, pp);
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      settings_used++;
      live_slots.delete();
      queue_random_msgs(count);
      wait_drained();
   endtask

   // Sender: predicts each accepted beat and offers the next one, with idle bursts.
   always @(posedge clock) begin : sender
      midi_msg_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall)
            predict_route(req_command, req_chan, req_note_num, req_velocity_in);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
               send_gap  <= $urandom_range(6, 0);
               req_valid <= 1'b0;
            end else if (pending_msgs.size() != 0) begin
               nxt = pending_msgs.pop_front();
               req_valid       <= 1'b1;
               req_command     <= nxt.command;
               req_chan        <= nxt.chan;
               req_note_num    <= nxt.note_num;
               req_velocity_in <= nxt.velocity_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted result beat and stalls in random bursts.
   always @(posedge clock) begin : receiver
      route_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (rsp_excluded === 1'b1) excluded_seen++;
            if (route_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result beat: excluded=%0b vel_used=%0d",
                           rsp_excluded, rsp_vel_used);
            end else begin
               want = route_expect.pop_front();
               if (rsp_excluded !== want.excluded || rsp_vel_used !== want.vel_used) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Result %0d: want excl=%0b vel=%0d, got excl=%0b vel=%0d",
                              results_checked, want.excluded, want.vel_used,
                              rsp_excluded, rsp_vel_used);
               end
            end
         end
         if (long_hold_active) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap != 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
            recv_gap  <= $urandom_range(6, 0);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Long hold-off on the result side, counted here so the sender keeps pushing.
   always @(posedge clock) begin
      if (reset)
         hold_count <= 0;
      else if (long_hold_active)
         hold_count <= hold_count + 1;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, route_expect.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : stimulus
      int p;
      logic [6:0] cl, chh, nl, nh, vl, vh;
      foreach (vel_table[i]) vel_table[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset settings, back to back: a note-off with no
      // earlier note-on, zero velocity, overwrites, and every command code.
      settings_used++;
      queue_msg(CMD_NOTE_OFF,    4'd0,  7'd0,   7'd0);
      queue_msg(CMD_NOTE_ON,     4'd0,  7'd0,   7'd0);
      queue_msg(CMD_NOTE_OFF,    4'd0,  7'd0,   7'd99);
      queue_msg(CMD_NOTE_ON,     4'd15, 7'd127, 7'd127);
      queue_msg(CMD_NOTE_OFF,    4'd15, 7'd127, 7'd0);
      queue_msg(CMD_NOTE_ON,     4'd15, 7'd127, 7'd1);
      queue_msg(CMD_NOTE_OFF,    4'd15, 7'd127, 7'd127);
      queue_msg(CMD_NOTE_ON,     4'd7,  7'd64,  7'd127);
      queue_msg(CMD_NOTE_ON,     4'd7,  7'd64,  7'd64);
      queue_msg(CMD_NOTE_OFF,    4'd7,  7'd64,  7'd5);
      queue_msg(CMD_NOTE_ON,     4'd8,  7'd5,   7'd33);
      queue_msg(CMD_NOTE_OFF,    4'd8,  7'd5,   7'd0);
      queue_msg(CMD_OTHER_VOICE, 4'd15, 7'd127, 7'd127);
      queue_msg(CMD_OTHER_VOICE, 4'd0,  7'd0,   7'd0);
      queue_msg(CMD_PROG_CHANGE, 4'd3,  7'd42,  7'd17);
      queue_msg(CMD_NOT_VOICE,         4'd15, 7'd127, 7'd127);
      queue_msg(CMD_NOT_VOICE + 3'd1,  4'd0,  7'd0,   7'd0);
      queue_msg(CMD_NOT_VOICE + 3'd2,  4'd9,  7'd60,  7'd100);
      queue_msg(CMD_NOT_VOICE + 3'd3,  4'd15, 7'd127, 7'd127);
      wait_drained();

      // Fixed settings at the extremes of every register.
      send_idle_pct = 20;
      recv_idle_pct = 20;
      run_phase(7'd0, 7'd31, 7'd0, 7'd127, 7'd0, 7'd127, 7'd1, PHASE_BEATS);
      run_phase(7'd1, 7'd16, 7'd0, 7'd127, 7'd0, 7'd127, 7'd0, PHASE_BEATS);

      // Back-pressure: the result side holds off while beats keep arriving.
      send_idle_pct = 0;
      recv_idle_pct = 10;
      hold_armed = 1'b1;
      run_phase(7'd1, 7'd16, 7'd20, 7'd100, 7'd10, 7'd110, 7'd1, 150);

      send_idle_pct = 30;
      recv_idle_pct = 0;
      run_phase(7'd0, 7'd0, 7'd0, 7'd127, 7'd0, 7'd127, 7'd1, PHASE_BEATS);
      run_phase(7'd16, 7'd16, 7'd127, 7'd127, 7'd127, 7'd127, 7'd1, PHASE_BEATS);
      send_idle_pct = 0;
      recv_idle_pct = 30;
      run_phase(7'h7F, 7'h5F, 7'd0, 7'd0, 7'd0, 7'd0, 7'h7E, PHASE_BEATS);
      run_phase(7'd9, 7'd4, 7'd100, 7'd20, 7'd90, 7'd10, 7'd1, PHASE_BEATS);
      run_phase(7'd2, 7'd15, 7'd60, 7'd60, 7'd1, 7'd1, 7'd1, PHASE_BEATS);

      // Random settings, mostly well-ordered windows with the odd inverted one.
      for (p = 0; p < 7; p++) begin
         send_idle_pct = 15 * $urandom_range(2, 0);
         recv_idle_pct = 15 * $urandom_range(2, 0);
         cl  = 7'($urandom_range(16, 1));
         chh = 7'($urandom_range(16, cl));
         nl  = 7'($urandom_range(100, 0));
         nh  = 7'($urandom_range(127, nl));
         vl  = 7'($urandom_range(100, 0));
         vh  = 7'($urandom_range(127, vl));
         if ($urandom_range(5, 0) == 0) begin
            cl = 7'($urandom_range(127, 0));
            nh = 7'($urandom_range(127, 0));
            vh = 7'($urandom_range(127, 0));
         end
         run_phase(cl, chh, nl, nh, vl, vh, 7'($urandom_range(127, 0)), PHASE_BEATS);
      end

      // Closing stretch with both sides running flat out.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(7'd1, 7'd16, 7'd0, 7'd127, 7'd0, 7'd127, 7'd1, PHASE_BEATS);

      repeat (10) @(posedge clock);
      $display("Checked %0d routing results from %0d messages under %0d register settings.",
               results_checked, msgs_queued, settings_used);
      $display("%0d went to the excluded output and %0d to the pass output; %0d mismatches.",
               excluded_seen, results_checked - excluded_seen, mismatches);
      if (mismatches == 0 && route_expect.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
